[rtl/usls_pkg.sv]
// ============================================================================
// usls_pkg
// Shared types and constants for the UTF-8 sanitizing line splitter.
// ============================================================================
package usls_pkg;

    localparam int LINE_COUNT_WIDTH = 16;
    localparam int CMP_W            = (LINE_COUNT_WIDTH > 16) ? LINE_COUNT_WIDTH : 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] LINE_LIMIT_RESET = 16'd200;

    typedef logic [LINE_COUNT_WIDTH-1:0] line_cnt_t;

    localparam line_cnt_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_EOL    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_FFFD,
        PH_CHAR,
        PH_END_BRK,
        PH_STATUS
    } phase_t;

    // One classified input byte: replacement chars first, then one char,
    // then end-of-buffer handling when last is set.
    typedef struct packed {
        logic [2:0]      fffd_cnt;
        logic [2:0]      chr_len;
        logic [3:0][7:0] chr_bytes;
        logic            chr_brk;
        logic            chr_cr;
        logic            chr_lf;
        logic            last;
        logic            nul;
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_byte;
        logic [15:0] line_number;
        logic        binary_seen;
        logic        lines_truncated;
    } result_t;

    function automatic logic [15:0] line_sat(input line_cnt_t v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w > CMP_W'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

endpackage

[rtl/utf8_sanitize_line_splitter_top.sv]
// ============================================================================
// utf8_sanitize_line_splitter_top
// UTF-8 sanitizer and line splitter, one raw byte in, text/line/status out.
// ============================================================================
// A byte that yields at most one result is taken at one byte per cycle
// while the output is not stalled, so plain ASCII text streams at one
// byte per cycle; its result passes through the job queue into the
// output register. The output sequencer works in steps: three per U+FFFD
// replacement, one per byte of a valid character, one per break or
// swallowed LF, one per byte that only extends a held sequence, and two at
// buffer end (closing break, if any, and status). A byte that yields two
// or more results marks its final one with run_last in a flush step. A
// four-entry job queue lets the validator keep accepting bytes while the
// sequencer works through a replacement burst. The user must write the
// line limit through the cfg channel only while the block is idle; the
// block does not enforce this, and there is no clearing pass after reset.
module utf8_sanitize_line_splitter_top import usls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_line_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_text_byte,
    output logic [15:0] m_line_number,
    output logic        m_binary_seen,
    output logic        m_lines_truncated,
    output logic        m_run_last
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic q_head_valid;
    job_t q_head;

    assign cfg_ready = 1'b1;

    usls_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .s_last_in (s_last_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    usls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .job_in     (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    usls_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_line_limit    (cfg_line_limit),
        .head_valid        (q_head_valid),
        .head              (q_head),
        .pop               (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_text_byte       (m_text_byte),
        .m_line_number     (m_line_number),
        .m_binary_seen     (m_binary_seen),
        .m_lines_truncated (m_lines_truncated),
        .m_run_last        (m_run_last)
    );

endmodule

[rtl/usls_front.sv]
// ============================================================================
// usls_front
// UTF-8 validator: holds partial sequences and turns each accepted byte
// into one job for the back sequencer.
// ============================================================================
module usls_front import usls_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_last_in,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  CH_VT   = 8'h0B;
    localparam logic [7:0]  CH_FF   = 8'h0C;
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_FS   = 8'h1C;
    localparam logic [7:0]  CH_RS   = 8'h1E;
    localparam logic [7:0]  NEL_B0  = 8'hC2;
    localparam logic [7:0]  NEL_B1  = 8'h85;
    localparam logic [7:0]  LS_B0   = 8'hE2;
    localparam logic [7:0]  LS_B1   = 8'h80;
    localparam logic [7:0]  LS_B2   = 8'hA8;
    localparam logic [7:0]  PS_B2   = 8'hA9;
    localparam logic [10:0] CP_MIN2 = 11'h080;
    localparam logic [15:0] CP_MIN3 = 16'h0800;
    localparam logic [15:0] SURR_LO = 16'hD800;
    localparam logic [15:0] SURR_HI = 16'hDFFF;
    localparam logic [20:0] CP_MIN4 = 21'h010000;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        if (c[7] == 1'b0)            return 3'd1;
        if (c[7:5] == 3'b110)        return 3'd2;
        if (c[7:4] == 4'b1110)       return 3'd3;
        if (c[7:3] == 5'b11110)      return 3'd4;
        return 3'd0;
    endfunction

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      hc_reg, hc_next;
    logic [2:0]      exp_reg, exp_next;

    logic            accept;
    logic            cont;
    logic            lead_now;
    logic            lead_fffd;
    logic            seq_ok;
    logic [2:0]      lead_len;
    logic [2:0]      pre_cnt;
    logic [3:0][7:0] seq;
    logic [10:0]     cp2;
    logic [15:0]     cp3;
    logic [20:0]     cp4;
    job_t            job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;
    assign q_job   = job;

    always_comb begin
        cont      = (s_byte_in[7:6] == 2'b10);
        lead_len  = lead_length(s_byte_in);
        held_next = held_reg;
        hc_next   = hc_reg;
        exp_next  = exp_reg;
        pre_cnt   = 3'd0;
        lead_now  = 1'b0;
        lead_fffd = 1'b0;
        job       = '0;
        job.last  = s_last_in;
        job.nul   = (s_byte_in == 8'h00);

        seq[0] = held_reg[0];
        seq[1] = (exp_reg == 3'd2) ? s_byte_in : held_reg[1];
        seq[2] = (exp_reg == 3'd3) ? s_byte_in : held_reg[2];
        seq[3] = s_byte_in;
        cp2    = {seq[0][4:0], seq[1][5:0]};
        cp3    = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
        cp4    = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
        case (exp_reg)
            3'd2:    seq_ok = (cp2 >= CP_MIN2);
            3'd3:    seq_ok = (cp3 >= CP_MIN3) && !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
            default: seq_ok = (cp4 >= CP_MIN4) && (cp4 <= CP_MAX);
        endcase

        if (hc_reg == 2'd0) begin
            lead_now = 1'b1;
        end else if (!cont) begin
            pre_cnt  = {1'b0, hc_reg};
            lead_now = 1'b1;
            hc_next  = 2'd0;
            exp_next = 3'd0;
        end else if (({1'b0, hc_reg} + 3'd1) < exp_reg) begin
            held_next[hc_reg] = s_byte_in;
            hc_next           = hc_reg + 2'd1;
        end else begin
            if (seq_ok) begin
                job.chr_len   = exp_reg;
                job.chr_bytes = seq;
            end else begin
                pre_cnt = exp_reg;
            end
            hc_next  = 2'd0;
            exp_next = 3'd0;
        end

        if (lead_now) begin
            case (lead_len)
                3'd0: begin
                    lead_fffd = 1'b1;
                end
                3'd1: begin
                    job.chr_len      = 3'd1;
                    job.chr_bytes[0] = s_byte_in;
                end
                default: begin
                    held_next[0] = s_byte_in;
                    hc_next      = 2'd1;
                    exp_next     = lead_len;
                end
            endcase
        end

        job.fffd_cnt = pre_cnt + {2'b00, lead_fffd};
        if (s_last_in) begin
            job.fffd_cnt = job.fffd_cnt + {1'b0, hc_next};
            hc_next      = 2'd0;
            exp_next     = 3'd0;
        end

        case (job.chr_len)
            3'd1: begin
                job.chr_brk = (job.chr_bytes[0] == CH_LF) || (job.chr_bytes[0] == CH_VT)
                           || (job.chr_bytes[0] == CH_FF) || (job.chr_bytes[0] == CH_CR)
                           || ((job.chr_bytes[0] >= CH_FS) && (job.chr_bytes[0] <= CH_RS));
                job.chr_cr  = (job.chr_bytes[0] == CH_CR);
                job.chr_lf  = (job.chr_bytes[0] == CH_LF);
            end
            3'd2: begin
                job.chr_brk = (job.chr_bytes[0] == NEL_B0) && (job.chr_bytes[1] == NEL_B1);
            end
            3'd3: begin
                job.chr_brk = (job.chr_bytes[0] == LS_B0) && (job.chr_bytes[1] == LS_B1)
                           && ((job.chr_bytes[2] == LS_B2) || (job.chr_bytes[2] == PS_B2));
            end
            default: begin
                job.chr_brk = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg  <= 2'd0;
            exp_reg <= 3'd0;
        end else if (accept) begin
            hc_reg  <= hc_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

[rtl/usls_queue.sv]
// ============================================================================
// usls_queue
// Short job queue between the validator and the output sequencer.
// ============================================================================
module usls_queue import usls_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[rtl/usls_back.sv]
// ============================================================================
// usls_back
// Output sequencer: expands jobs into text, end-of-line and status
// transfers, tracks lines and drives the output register.
// ============================================================================
module usls_back import usls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_line_limit,
    input  logic        head_valid,
    input  job_t        head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_text_byte,
    output logic [15:0] m_line_number,
    output logic        m_binary_seen,
    output logic        m_lines_truncated,
    output logic        m_run_last
);

    localparam logic [7:0] REP_B0 = 8'hEF;
    localparam logic [7:0] REP_B1 = 8'hBF;
    localparam logic [7:0] REP_B2 = 8'hBD;

    phase_t      phase_reg, phase_next, eff_phase, after_char, after_fffd;
    logic [1:0]  bidx_reg, bidx_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    line_cnt_t   cnt_reg, cnt_next;
    logic        swallow_reg, swallow_next;
    logic        at_start_reg, at_start_next;
    logic        nul_reg, nul_next;
    logic [15:0] line_limit_reg;

    result_t     pend_reg;
    logic        pend_valid_reg;
    logic        flush_reg;
    result_t     out_reg;
    logic        out_last_reg;
    logic        m_valid_reg;

    result_t     gen;
    logic        gen_valid;
    logic        step_final;
    logic        lt_max;
    logic        gt_max;
    line_cnt_t   cnt_inc;
    logic        do_push;
    result_t     push_res;
    logic        push_last;
    logic        out_space;
    logic        push_fire;
    logic        adv;
    logic [7:0]  rep_byte;

    assign lt_max  = CMP_W'(cnt_reg) < CMP_W'(line_limit_reg);
    assign gt_max  = CMP_W'(cnt_reg) > CMP_W'(line_limit_reg);
    assign cnt_inc = (cnt_reg != COUNT_MAX) ? cnt_reg + LINE_COUNT_WIDTH'(1) : cnt_reg;

    always_comb begin
        case (bidx_reg)
            2'd0:    rep_byte = REP_B0;
            2'd1:    rep_byte = REP_B1;
            default: rep_byte = REP_B2;
        endcase
    end

    always_comb begin
        after_char = head.last ? PH_END_BRK : PH_START;
        after_fffd = (head.chr_len != 3'd0) ? PH_CHAR : after_char;
        if (phase_reg != PH_START) begin
            eff_phase = phase_reg;
        end else if (head.fffd_cnt != 3'd0) begin
            eff_phase = PH_FFFD;
        end else begin
            eff_phase = after_fffd;
        end

        phase_next       = eff_phase;
        bidx_next        = bidx_reg;
        fcnt_next        = fcnt_reg;
        cnt_next         = cnt_reg;
        swallow_next     = swallow_reg;
        at_start_next    = at_start_reg;
        nul_next         = nul_reg | head.nul;
        gen              = '0;
        gen.kind         = KIND_TEXT;
        gen.line_number  = line_sat(cnt_reg);
        gen_valid        = 1'b0;

        case (eff_phase)
            PH_FFFD: begin
                gen_valid     = lt_max;
                gen.text_byte = rep_byte;
                swallow_next  = 1'b0;
                at_start_next = 1'b0;
                if (bidx_reg == 2'd2) begin
                    bidx_next = 2'd0;
                    fcnt_next = fcnt_reg + 3'd1;
                    if ((fcnt_reg + 3'd1) == head.fffd_cnt) begin
                        fcnt_next  = 3'd0;
                        phase_next = after_fffd;
                    end
                end else begin
                    bidx_next = bidx_reg + 2'd1;
                end
            end
            PH_CHAR: begin
                if (head.chr_lf && swallow_reg) begin
                    swallow_next = 1'b0;
                    phase_next   = after_char;
                end else if (head.chr_brk) begin
                    gen_valid     = lt_max;
                    gen.kind      = KIND_EOL;
                    cnt_next      = cnt_inc;
                    at_start_next = 1'b1;
                    swallow_next  = head.chr_cr;
                    phase_next    = after_char;
                end else begin
                    gen_valid     = lt_max;
                    gen.text_byte = head.chr_bytes[bidx_reg];
                    swallow_next  = 1'b0;
                    at_start_next = 1'b0;
                    if (({1'b0, bidx_reg} + 3'd1) == head.chr_len) begin
                        bidx_next  = 2'd0;
                        phase_next = after_char;
                    end else begin
                        bidx_next = bidx_reg + 2'd1;
                    end
                end
            end
            PH_END_BRK: begin
                if (!at_start_reg) begin
                    gen_valid = lt_max;
                    gen.kind  = KIND_EOL;
                    cnt_next  = cnt_inc;
                end
                phase_next = PH_STATUS;
            end
            PH_STATUS: begin
                gen_valid           = 1'b1;
                gen.kind            = KIND_STATUS;
                gen.binary_seen     = nul_reg | head.nul;
                gen.lines_truncated = gt_max;
                cnt_next            = '0;
                swallow_next        = 1'b0;
                at_start_next       = 1'b0;
                nul_next            = 1'b0;
                phase_next          = PH_START;
            end
            default: begin
                phase_next = PH_START;
            end
        endcase

        step_final = (phase_next == PH_START);
    end

    assign out_space = !m_valid_reg || m_ready;

    always_comb begin
        do_push   = 1'b0;
        push_res  = pend_reg;
        push_last = 1'b0;
        adv       = 1'b0;
        if (flush_reg) begin
            do_push   = 1'b1;
            push_last = 1'b1;
        end else if (head_valid) begin
            if (gen_valid && pend_valid_reg) begin
                do_push = 1'b1;
            end else if (gen_valid && step_final) begin
                do_push   = 1'b1;
                push_res  = gen;
                push_last = 1'b1;
            end else if (pend_valid_reg && step_final) begin
                do_push   = 1'b1;
                push_last = 1'b1;
            end
            adv = !do_push || out_space;
        end
    end

    assign push_fire = do_push && out_space;
    assign pop       = adv && step_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
        end else if (adv) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bidx_reg       <= 2'd0;
            fcnt_reg       <= 3'd0;
            cnt_reg        <= '0;
            swallow_reg    <= 1'b0;
            at_start_reg   <= 1'b0;
            nul_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            flush_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            line_limit_reg <= LINE_LIMIT_RESET;
        end else begin
            if (cfg_valid) begin
                line_limit_reg <= cfg_line_limit;
            end
            if (flush_reg && out_space) begin
                flush_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (adv) begin
                bidx_reg     <= bidx_next;
                fcnt_reg     <= fcnt_next;
                cnt_reg      <= cnt_next;
                swallow_reg  <= swallow_next;
                at_start_reg <= at_start_next;
                nul_reg      <= nul_next;
                if (gen_valid) begin
                    if (pend_valid_reg) begin
                        flush_reg <= step_final;
                    end else if (!step_final) begin
                        pend_valid_reg <= 1'b1;
                    end
                end else if (step_final) begin
                    pend_valid_reg <= 1'b0;
                end
            end
            if (push_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && gen_valid) begin
            pend_reg <= gen;
        end
        if (push_fire) begin
            out_reg      <= push_res;
            out_last_reg <= push_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = out_reg.kind;
    assign m_text_byte       = out_reg.text_byte;
    assign m_line_number     = out_reg.line_number;
    assign m_binary_seen     = out_reg.binary_seen;
    assign m_lines_truncated = out_reg.lines_truncated;
    assign m_run_last        = out_last_reg;

endmodule

[rtl/usls_checker.sv]
// ============================================================================
// usls_checker
// Port-level checks on the result channel of the line splitter.
// ============================================================================
module usls_checker import usls_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_text_byte,
    input logic [15:0] m_line_number,
    input logic        m_binary_seen,
    input logic        m_lines_truncated,
    input logic        m_run_last
);

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_STATUS) |-> m_run_last)
        else $error("status transfer without run_last");

    a_flags_only_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_STATUS) |-> !m_binary_seen && !m_lines_truncated)
        else $error("status flags set on a non-status transfer");

    a_byte_only_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_TEXT) |-> (m_text_byte == 8'h00))
        else $error("text byte set on a non-text transfer");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_TEXT) || (m_kind == KIND_EOL)
                 || (m_kind == KIND_STATUS))
        else $error("illegal result kind");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_text_byte)
                             && $stable(m_line_number) && $stable(m_run_last))
        else $error("stalled result transfer changed");

endmodule

bind utf8_sanitize_line_splitter_top usls_checker u_usls_checker (.*);
